@@ hdl/mre_pkg.sv @@
`default_nettype none
package mre_pkg;

   localparam int NUM_REGS = 7;
   localparam int REG_W    = 63;
   localparam int IDX_W    = 3;

   localparam logic [16:0] ITEM_CAP = 17'd65536;
   localparam logic [47:0] SUM_MAX  = 48'hFFFF_FFFF_FFFF;

   localparam logic signed [63:0] S40_HI   = 64'sh0000_007F_FFFF_FFFF;
   localparam logic signed [63:0] S40_LO   = -64'sh0000_0080_0000_0000;
   localparam logic signed [42:0] DIFF_MAX = 43'sd2147483647;
   localparam logic [40:0]        PIX_SAT  = 41'h100_0000_0000;

   localparam logic [5:0] DIV_PIX_LAST  = 6'd39;
   localparam logic [5:0] DIV_MEAN_LAST = 6'd47;
   localparam logic [4:0] SQRT_LAST     = 5'd31;

   typedef enum logic [2:0] {
      REG_ROT0  = 3'd0,
      REG_ROT1  = 3'd1,
      REG_ROT2  = 3'd2,
      REG_TRANS = 3'd3,
      REG_CAM0  = 3'd4,
      REG_CAM1  = 3'd5,
      REG_CAM2  = 3'd6
   } reg_idx_type;

   localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
      63'd524288, 63'd1099511627776, 63'd2305843009213693952, 63'd0,
      63'd256, 63'd536870912, 63'd1125899906842624
   };

   typedef enum logic [3:0] {
      GRP_C0  = 4'd0,
      GRP_C1  = 4'd1,
      GRP_C2  = 4'd2,
      GRP_S   = 4'd3,
      GRP_M   = 4'd4,
      GRP_PR0 = 4'd5,
      GRP_PR1 = 4'd6,
      GRP_PR2 = 4'd7,
      GRP_SQ  = 4'd8
   } grp_type;

   typedef enum logic [1:0] {
      DIV_U    = 2'd0,
      DIV_V    = 2'd1,
      DIV_MEAN = 2'd2
   } div_mode_type;

   typedef struct packed {
      logic signed [31:0] model_x;
      logic signed [31:0] model_y;
      logic signed [31:0] model_z;
      logic signed [17:0] normal_x;
      logic signed [17:0] normal_y;
      logic signed [17:0] normal_z;
      logic signed [31:0] mirror_dist;
      logic signed [31:0] obs_u;
      logic signed [31:0] obs_v;
      logic               last;
   } req_type;

   typedef struct packed {
      logic         load;
      logic         mul_en;
      logic         acc_clr;
      grp_type      grp;
      logic [1:0]   mul_k;
      logic         store_en;
      logic [1:0]   store_k;
      logic         div_start;
      div_mode_type div_mode;
      logic         sqrt_start;
      logic         fault_set;
      logic         upd_en;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic sqrt_busy;
      logic pr2_pos;
      logic count_full;
      logic last;
      logic rsp_full;
   } status_type;

   function automatic logic signed [20:0] field(input logic [REG_W-1:0] r,
                                                input logic [1:0] col);
      logic signed [20:0] f;
      case (col)
         2'd0:    f = r[20:0];
         2'd1:    f = r[41:21];
         default: f = r[62:42];
      endcase
      return f;
   endfunction

endpackage
`default_nettype wire

@@ hdl/mre_if.sv @@
`default_nettype none
interface mre_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] model_x;
   logic signed [31:0] model_y;
   logic signed [31:0] model_z;
   logic signed [17:0] normal_x;
   logic signed [17:0] normal_y;
   logic signed [17:0] normal_z;
   logic signed [31:0] mirror_dist;
   logic signed [31:0] obs_u;
   logic signed [31:0] obs_v;
   logic               last;
   modport source(output valid, model_x, model_y, model_z, normal_x, normal_y, normal_z,
                  mirror_dist, obs_u, obs_v, last, input ready);
   modport sink(input valid, model_x, model_y, model_z, normal_x, normal_y, normal_z,
                mirror_dist, obs_u, obs_v, last, output ready);
endinterface

interface mre_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] mean_error;
   logic [16:0] item_total;
   logic        depth_fault;
   modport source(output valid, mean_error, item_total, depth_fault, input ready);
   modport sink(input valid, mean_error, item_total, depth_fault, output ready);
endinterface
`default_nettype wire

@@ hdl/mre_datapath.sv @@
`default_nettype none
module mre_datapath import mre_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0] csr_wdata,
   input  req_type          req_data,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic [31:0]      rsp_mean_error,
   output logic [16:0]      rsp_item_total,
   output logic             rsp_depth_fault
);

   function automatic logic signed [39:0] sat40(input logic signed [63:0] x);
      logic signed [39:0] r;
      if (x > S40_HI)      r = S40_HI[39:0];
      else if (x < S40_LO) r = S40_LO[39:0];
      else                 r = x[39:0];
      return r;
   endfunction

   logic [REG_W-1:0] csr_ff [NUM_REGS];
   req_type          req_ff;

   logic signed [31:0] pt [3];
   logic signed [17:0] nv [3];

   logic signed [39:0] c_ff [3];
   logic signed [41:0] s_ff;
   logic signed [39:0] m_ff [3];
   logic signed [63:0] pr_ff [3];
   logic signed [63:0] prod_ff;
   logic signed [63:0] acc_ff;
   logic               add_ff;

   logic signed [41:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [73:0] mul_full;

   logic [30:0] du_ff, dv_ff;
   logic [31:0] mean_ff;

   logic [63:0]  rem_ff;
   logic [47:0]  q_ff;
   logic [62:0]  den_ff;
   logic [5:0]   dcnt_ff;
   logic         dbusy_ff, dneg_ff, dsat_ff;
   div_mode_type dmode_ff;

   logic [63:0] v_ff, res_ff, bit_ff;
   logic [4:0]  scnt_ff;
   logic        sbusy_ff;

   logic [47:0] sum_ff;
   logic [16:0] cnt_ff;
   logic        fault_ff;

   logic        rsp_valid_ff, rsp_fault_ff;
   logic [31:0] rsp_mean_ff;
   logic [16:0] rsp_total_ff;

   assign pt[0] = req_ff.model_x;
   assign pt[1] = req_ff.model_y;
   assign pt[2] = req_ff.model_z;
   assign nv[0] = req_ff.normal_x;
   assign nv[1] = req_ff.normal_y;
   assign nv[2] = req_ff.normal_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) csr_ff[i] <= REG_RESET[i];
      end else if (csr_wr_en && (csr_index < IDX_W'(NUM_REGS))) begin
         csr_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.grp)
         GRP_C0: begin
            mul_a = 42'(pt[cmd.mul_k]);
            mul_b = 32'(field(csr_ff[REG_ROT0], cmd.mul_k));
         end
         GRP_C1: begin
            mul_a = 42'(pt[cmd.mul_k]);
            mul_b = 32'(field(csr_ff[REG_ROT1], cmd.mul_k));
         end
         GRP_C2: begin
            mul_a = 42'(pt[cmd.mul_k]);
            mul_b = 32'(field(csr_ff[REG_ROT2], cmd.mul_k));
         end
         GRP_S: begin
            mul_a = 42'(c_ff[cmd.mul_k]);
            mul_b = 32'(nv[cmd.mul_k]);
         end
         GRP_M: begin
            mul_a = s_ff;
            mul_b = 32'(nv[cmd.mul_k]);
         end
         GRP_PR0: begin
            mul_a = 42'(m_ff[cmd.mul_k]);
            mul_b = 32'(field(csr_ff[REG_CAM0], cmd.mul_k));
         end
         GRP_PR1: begin
            mul_a = 42'(m_ff[cmd.mul_k]);
            mul_b = 32'(field(csr_ff[REG_CAM1], cmd.mul_k));
         end
         GRP_PR2: begin
            mul_a = 42'(m_ff[cmd.mul_k]);
            mul_b = 32'(field(csr_ff[REG_CAM2], cmd.mul_k));
         end
         GRP_SQ: begin
            mul_a = (cmd.mul_k == 2'd0) ? $signed({11'd0, du_ff}) : $signed({11'd0, dv_ff});
            mul_b = (cmd.mul_k == 2'd0) ? $signed({1'b0, du_ff}) : $signed({1'b0, dv_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) add_ff <= 1'b0;
      else       add_ff <= cmd.mul_en;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) prod_ff <= mul_full[63:0];
      if (cmd.acc_clr)  acc_ff <= '0;
      else if (add_ff)  acc_ff <= acc_ff + prod_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.store_en) begin
         case (cmd.grp)
            GRP_C0: c_ff[0] <= 40'((acc_ff >>> 19)
                               + (64'(field(csr_ff[REG_TRANS], 2'd0)) <<< 8));
            GRP_C1: c_ff[1] <= 40'((acc_ff >>> 19)
                               + (64'(field(csr_ff[REG_TRANS], 2'd1)) <<< 8));
            GRP_C2: c_ff[2] <= 40'((acc_ff >>> 19)
                               + (64'(field(csr_ff[REG_TRANS], 2'd2)) <<< 8));
            GRP_S:   s_ff <= 42'((acc_ff >>> 16) + 64'(req_ff.mirror_dist));
            GRP_M:   m_ff[cmd.store_k] <= sat40(64'(c_ff[cmd.store_k]) - (prod_ff >>> 15));
            GRP_PR0: pr_ff[0] <= acc_ff;
            GRP_PR1: pr_ff[1] <= acc_ff;
            GRP_PR2: pr_ff[2] <= acc_ff;
            default: ;
         endcase
      end
   end

   // divider shared by both pixel quotients and the final mean
   logic signed [63:0] dnum;
   logic [63:0]        dmag;
   logic [63:0]        rem_sh, rem_n;
   logic               ge;
   logic [47:0]        q_n;
   logic               dlast;
   logic [40:0]        pmag;
   logic signed [41:0] pix;
   logic signed [42:0] diff, diffc;
   logic [30:0]        dabs;

   always_comb begin
      dnum   = (cmd.div_mode == DIV_V) ? pr_ff[1] : pr_ff[0];
      dmag   = dnum[63] ? 64'(-dnum) : 64'(dnum);
      rem_sh = {rem_ff[62:0], q_ff[47]};
      ge     = rem_sh >= {1'b0, den_ff};
      rem_n  = ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
      q_n    = {q_ff[46:0], ge};
      dlast  = dcnt_ff == ((dmode_ff == DIV_MEAN) ? DIV_MEAN_LAST : DIV_PIX_LAST);
      pmag   = dsat_ff ? PIX_SAT : {1'b0, q_n[39:0]};
      pix    = dneg_ff ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
      diff   = 43'(pix) - ((dmode_ff == DIV_V) ? 43'(req_ff.obs_v) : 43'(req_ff.obs_u));
      if (diff > DIFF_MAX)       diffc = DIFF_MAX;
      else if (diff < -DIFF_MAX) diffc = -DIFF_MAX;
      else                       diffc = diff;
      dabs   = diffc[42] ? 31'(-diffc) : diffc[30:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         dbusy_ff <= 1'b1;
      end else if (dbusy_ff && dlast) begin
         dbusy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dmode_ff <= cmd.div_mode;
         dcnt_ff  <= '0;
         if (cmd.div_mode == DIV_MEAN) begin
            rem_ff  <= '0;
            q_ff    <= sum_ff;
            den_ff  <= 63'(cnt_ff);
            dneg_ff <= 1'b0;
            dsat_ff <= 1'b0;
         end else begin
            rem_ff  <= dmag >> 24;
            q_ff    <= {dmag[23:0], 24'd0};
            den_ff  <= pr_ff[2][62:0];
            dneg_ff <= dnum[63];
            dsat_ff <= (dmag >> 24) >= {1'b0, pr_ff[2][62:0]};
         end
      end else if (dbusy_ff) begin
         rem_ff  <= rem_n;
         q_ff    <= q_n;
         dcnt_ff <= dcnt_ff + 6'd1;
         if (dlast) begin
            case (dmode_ff)
               DIV_U:   du_ff <= dabs;
               DIV_V:   dv_ff <= dabs;
               default: mean_ff <= (cnt_ff == '0) ? 32'd0
                                 : ((q_n[47:32] != '0) ? 32'hFFFF_FFFF : q_n[31:0]);
            endcase
         end
      end
   end

   // bitwise integer square root, one result bit per step
   logic [63:0] strial;

   assign strial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sbusy_ff <= 1'b0;
      end else if (cmd.sqrt_start) begin
         sbusy_ff <= 1'b1;
      end else if (sbusy_ff && (scnt_ff == SQRT_LAST)) begin
         sbusy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         v_ff    <= 64'(acc_ff);
         res_ff  <= '0;
         bit_ff  <= 64'd1 << 62;
         scnt_ff <= '0;
      end else if (sbusy_ff) begin
         if (v_ff >= strial) begin
            v_ff   <= v_ff - strial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff  <= bit_ff >> 2;
         scnt_ff <= scnt_ff + 5'd1;
      end
   end

   logic [48:0] sum_next;

   assign sum_next = {1'b0, sum_ff} + 49'(res_ff[31:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         cnt_ff       <= '0;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            sum_ff       <= '0;
            cnt_ff       <= '0;
            fault_ff     <= 1'b0;
            rsp_valid_ff <= 1'b1;
            rsp_mean_ff  <= mean_ff;
            rsp_total_ff <= cnt_ff;
            rsp_fault_ff <= fault_ff;
         end else begin
            if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
            if (cmd.upd_en) begin
               sum_ff <= sum_next[48] ? SUM_MAX : sum_next[47:0];
               cnt_ff <= cnt_ff + 17'd1;
            end
            if (cmd.fault_set) fault_ff <= 1'b1;
         end
      end
   end

   assign status.div_busy   = dbusy_ff;
   assign status.sqrt_busy  = sbusy_ff;
   assign status.pr2_pos    = !pr_ff[2][63] && (pr_ff[2] != '0);
   assign status.count_full = cnt_ff >= ITEM_CAP;
   assign status.last       = req_ff.last;
   assign status.rsp_full   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mean_error  = rsp_mean_ff;
   assign rsp_item_total  = rsp_total_ff;
   assign rsp_depth_fault = rsp_fault_ff;

endmodule
`default_nettype wire

@@ hdl/mre_ctrl.sv @@
`default_nettype none
module mre_ctrl import mre_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_START = 10'b00_0000_0010,
      ST_MAC   = 10'b00_0000_0100,
      ST_CHK   = 10'b00_0000_1000,
      ST_DIVU  = 10'b00_0001_0000,
      ST_DIVV  = 10'b00_0010_0000,
      ST_SQ    = 10'b00_0100_0000,
      ST_SQRT  = 10'b00_1000_0000,
      ST_UPD   = 10'b01_0000_0000,
      ST_MEAN  = 10'b10_0000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] step_ff, step_in;
   logic       end_ff, end_in;
   logic [2:0] ph;

   assign ph = step_ff[2:0];

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      end_in   = 1'b0;
      cmd      = '0;
      cmd.grp  = GRP_C0;
      cmd.div_mode = DIV_U;
      if (end_ff) begin
         // wrap up the request: start the mean or return to idle
         if (status.last) begin
            cmd.div_start = 1'b1;
            cmd.div_mode  = DIV_MEAN;
            state_in      = ST_MEAN;
         end else begin
            state_in = ST_IDLE;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               cmd.load = req_valid;
               if (req_valid) state_in = ST_START;
            end
            ST_START: begin
               step_in = '0;
               if (status.count_full) end_in = 1'b1;
               else                   state_in = ST_MAC;
            end
            ST_MAC: begin
               cmd.grp   = grp_type'({1'b0, step_ff[5:3]});
               cmd.mul_k = ph[1:0];
               cmd.mul_en = ph < 3'd3;
               if (cmd.grp == GRP_M) begin
                  cmd.store_en = (ph >= 3'd1) && (ph <= 3'd3);
                  cmd.store_k  = ph[1:0] - 2'd1;
               end else begin
                  cmd.acc_clr  = ph == 3'd0;
                  cmd.store_en = ph == 3'd4;
               end
               step_in = step_ff + 6'd1;
               if (step_ff == 6'd63) state_in = ST_CHK;
            end
            ST_CHK: begin
               if (status.pr2_pos) begin
                  cmd.div_start = 1'b1;
                  cmd.div_mode  = DIV_U;
                  state_in      = ST_DIVU;
               end else begin
                  cmd.fault_set = 1'b1;
                  end_in        = 1'b1;
               end
            end
            ST_DIVU: begin
               if (!status.div_busy) begin
                  cmd.div_start = 1'b1;
                  cmd.div_mode  = DIV_V;
                  state_in      = ST_DIVV;
               end
            end
            ST_DIVV: begin
               step_in = '0;
               if (!status.div_busy) state_in = ST_SQ;
            end
            ST_SQ: begin
               cmd.grp     = GRP_SQ;
               cmd.mul_k   = step_ff[1:0];
               cmd.mul_en  = step_ff < 6'd2;
               cmd.acc_clr = step_ff == 6'd0;
               step_in     = step_ff + 6'd1;
               if (step_ff == 6'd3) begin
                  cmd.sqrt_start = 1'b1;
                  state_in       = ST_SQRT;
               end
            end
            ST_SQRT: begin
               if (!status.sqrt_busy) state_in = ST_UPD;
            end
            ST_UPD: begin
               cmd.upd_en = 1'b1;
               end_in     = 1'b1;
            end
            ST_MEAN: begin
               if (!status.div_busy && !status.rsp_full) begin
                  cmd.out_load = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         end_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         end_ff   <= end_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE) && !end_ff;

endmodule
`default_nettype wire

@@ hdl/mirror_reprojection_error_unit.sv @@
`default_nettype none
// Mirror-reflected reprojection error unit. Each request carries a model point, a mirror
// plane and an observed pixel; the point is rotated, translated, reflected in the mirror,
// projected with the camera matrix and divided by depth, and the Euclidean pixel error is
// added to a saturating sum. The request marked last returns the mean error, the point
// count and a depth fault flag, then clears the sums. One request is worked at a time:
// a counted point passes through 64 steps of the shared multiply-accumulate unit, two
// passes of the serial divider and the square root; a point with depth not positive ends
// after the multiply-accumulate steps, a point beyond the count limit skips all of them,
// and the last request adds the mean division. The result register lets the next request
// enter while a result waits. Configuration registers are to be written through csr_*
// while idle; the user is bound to this, the block itself does not enforce it.
module mirror_reprojection_error_unit import mre_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   mre_req_if.sink          req_ch,
   mre_rsp_if.source        rsp_ch,
   input  logic             csr_wr_en,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0] csr_wdata
);

   req_type    req_data;
   cmd_type    cmd;
   status_type status;

   assign req_data.model_x     = req_ch.model_x;
   assign req_data.model_y     = req_ch.model_y;
   assign req_data.model_z     = req_ch.model_z;
   assign req_data.normal_x    = req_ch.normal_x;
   assign req_data.normal_y    = req_ch.normal_y;
   assign req_data.normal_z    = req_ch.normal_z;
   assign req_data.mirror_dist = req_ch.mirror_dist;
   assign req_data.obs_u       = req_ch.obs_u;
   assign req_data.obs_v       = req_ch.obs_v;
   assign req_data.last        = req_ch.last;

   mre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mre_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_data        (req_data),
      .cmd             (cmd),
      .status          (status),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_mean_error  (rsp_ch.mean_error),
      .rsp_item_total  (rsp_ch.item_total),
      .rsp_depth_fault (rsp_ch.depth_fault)
   );

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request accepted while another is in flight");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(status.div_busy && status.sqrt_busy))
      else $error("divider and square root busy together");

   a_empty_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.item_total == '0) |-> rsp_ch.mean_error == '0)
      else $error("nonzero mean with no points counted");

endmodule
`default_nettype wire

@@ tb/tb_mirror_reprojection_error_unit.sv @@
`default_nettype none
module tb_mirror_reprojection_error_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import mre_pkg::*;

   typedef struct {
      logic [31:0] mean_error;
      logic [16:0] item_total;
      logic        depth_fault;
   } mean_result_type;

   logic clock;
   logic reset;
   logic             csr_wr_en;
   logic [IDX_W-1:0] csr_index;
   logic [REG_W-1:0] csr_wdata;

   mre_req_if req_ch();
   mre_rsp_if rsp_ch();

   mirror_reprojection_error_unit i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   logic [REG_W-1:0] cfg_shadow [NUM_REGS];
   longint unsigned  err_total;
   int unsigned      pt_count;
   bit               fault_flag;
   mean_result_type  pending_means [$];
   int  error_count = 0;
   bit  idle_on = 1;
   bit  long_hold_req = 0;
   int  quiet_cycles = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic longint cfg_field(int r, int col);
      logic signed [20:0] f;
      f = cfg_shadow[r][21*col +: 21];
      return longint'(f);
   endfunction

   function automatic longint sat40(longint x);
      if (x > 64'sh7F_FFFF_FFFF) return 64'sh7F_FFFF_FFFF;
      if (x < -64'sh80_0000_0000) return -64'sh80_0000_0000;
      return x;
   endfunction

   function automatic longint pixel_quot(longint num, longint w);
      longint unsigned a, den, ip, rem, frac, mag;
      a = (num < 0) ? longint'(-num) : longint'(num);
      den = w;
      ip = a / den;
      rem = a % den;
      frac = 0;
      if (ip >= 64'd16777216) begin
         mag = 64'd1099511627776;
      end else begin
         for (int i = 0; i < 16; i++) begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= den) begin
               rem = rem - den;
               frac = frac | 1;
            end
         end
         mag = (ip << 16) | frac;
      end
      return (num < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint unsigned clamp_mag(longint x);
      if (x > 64'sd2147483647) x = 64'sd2147483647;
      if (x < -64'sd2147483647) x = -64'sd2147483647;
      return (x < 0) ? longint'(-x) : longint'(x);
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   task automatic accumulate_point(req_type it);
      longint p[3], nv[3], c[3], m[3], pr[3];
      longint s, acc;
      longint unsigned du, dv, err;
      mean_result_type res;
      p[0] = it.model_x; p[1] = it.model_y; p[2] = it.model_z;
      nv[0] = it.normal_x; nv[1] = it.normal_y; nv[2] = it.normal_z;
      if (pt_count < ITEM_CAP) begin
         for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += cfg_field(r, k) * p[k];
            c[r] = (acc >>> 19) + cfg_field(REG_TRANS, r) * 256;
         end
         s = ((nv[0] * c[0] + nv[1] * c[1] + nv[2] * c[2]) >>> 16) + longint'(it.mirror_dist);
         for (int r = 0; r < 3; r++) m[r] = sat40(c[r] - ((s * nv[r]) >>> 15));
         for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += cfg_field(REG_CAM0 + r, k) * m[k];
            pr[r] = acc;
         end
         if (pr[2] <= 0) begin
            fault_flag = 1;
         end else begin
            du = clamp_mag(pixel_quot(pr[0], pr[2]) - longint'(it.obs_u));
            dv = clamp_mag(pixel_quot(pr[1], pr[2]) - longint'(it.obs_v));
            err = floor_sqrt(du * du + dv * dv);
            err_total += err;
            if (err_total > 64'hFFFF_FFFF_FFFF) err_total = 64'hFFFF_FFFF_FFFF;
            pt_count++;
         end
      end
      if (it.last) begin
         res.mean_error = 0;
         if (pt_count != 0) begin
            acc = err_total / pt_count;
            res.mean_error = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
         end
         res.item_total = pt_count[16:0];
         res.depth_fault = fault_flag;
         pending_means.push_back(res);
         err_total = 0;
         pt_count = 0;
         fault_flag = 0;
      end
   endtask

   task automatic send_point(req_type it);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_ch.valid       <= 1;
      req_ch.model_x     <= it.model_x;
      req_ch.model_y     <= it.model_y;
      req_ch.model_z     <= it.model_z;
      req_ch.normal_x    <= it.normal_x;
      req_ch.normal_y    <= it.normal_y;
      req_ch.normal_z    <= it.normal_z;
      req_ch.mirror_dist <= it.mirror_dist;
      req_ch.obs_u       <= it.obs_u;
      req_ch.obs_v       <= it.obs_v;
      req_ch.last        <= it.last;
      do @(posedge clock); while (!req_ch.ready);
      accumulate_point(it);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx < NUM_REGS) cfg_shadow[idx] = val;
   endtask

   task automatic load_config(logic [REG_W-1:0] vals [NUM_REGS]);
      for (int i = 0; i < NUM_REGS; i++) write_reg(i[IDX_W-1:0], vals[i]);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   function automatic logic [REG_W-1:0] pack3(int a, int b, int c);
      logic [20:0] fa, fb, fc;
      fa = a[20:0]; fb = b[20:0]; fc = c[20:0];
      return {fc, fb, fa};
   endfunction

   function automatic int rnd_signed(int mag);
      return int'($urandom_range(0, 2 * mag)) - mag;
   endfunction

   function automatic req_type plausible_point(bit last_flag);
      req_type it;
      it.model_x     = rnd_signed(1 << 20);
      it.model_y     = rnd_signed(1 << 20);
      it.model_z     = $urandom_range(1 << 16, 1 << 21);
      it.normal_x    = 18'(rnd_signed(40000));
      it.normal_y    = 18'(rnd_signed(40000));
      it.normal_z    = 18'(rnd_signed(65536));
      it.mirror_dist = rnd_signed(1 << 21);
      it.obs_u       = rnd_signed(1 << 22);
      it.obs_v       = rnd_signed(1 << 22);
      it.last        = last_flag;
      return it;
   endfunction

   function automatic req_type random_point();
      req_type it;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         it = plausible_point(0);
      end else if (pick < 9) begin
         it.model_x = $urandom; it.model_y = $urandom; it.model_z = $urandom;
         it.normal_x = 18'($urandom); it.normal_y = 18'($urandom);
         it.normal_z = 18'($urandom);
         it.mirror_dist = $urandom; it.obs_u = $urandom; it.obs_v = $urandom;
      end else begin
         it.model_x = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         it.model_y = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         it.model_z = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0000_0001;
         it.normal_x = $urandom_range(0, 1) ? 18'h1FFFF : 18'h20000;
         it.normal_y = $urandom_range(0, 1) ? 18'h1FFFF : 18'h20000;
         it.normal_z = $urandom_range(0, 1) ? 18'h1FFFF : 18'h20000;
         it.mirror_dist = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         it.obs_u = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         it.obs_v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      it.last = ($urandom_range(0, 11) == 0);
      return it;
   endfunction

   task automatic run_points(int n);
      req_type it;
      for (int i = 0; i < n; i++) begin
         it = random_point();
         if (i == n - 1) it.last = 1;
         send_point(it);
      end
   endtask

   task automatic test_directed();
      req_type it;
      it = '0;
      send_point(it);
      it = plausible_point(0);
      send_point(it);
      it = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0};
      send_point(it);
      it = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 18'h20000, 18'h20000, 18'h20000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0};
      send_point(it);
      it = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 18'd0, 18'd0, 18'd0, 32'd0,
             32'h8000_0000, 32'h7FFF_FFFF, 1'b0};
      send_point(it);
      it = '{32'd65536, 32'd0, 32'd65536, 18'h20000, 18'h1FFFF, 18'd0, 32'd65536,
             32'd0, 32'd0, 1'b0};
      send_point(it);
      it = '{32'd0, 32'd0, 32'd131072, 18'd0, 18'd0, 18'd65536, 32'd0,
             32'h8000_0000, 32'h7FFF_FFFF, 1'b1};
      send_point(it);
      it = plausible_point(1);
      it.model_z = -it.model_z;
      send_point(it);
      it = '0;
      it.model_z = 32'd65536;
      it.last = 1;
      send_point(it);
      for (int i = 0; i < 8; i++) send_point(plausible_point(i == 7));
      wait_drained();
   endtask

   task automatic test_config_sweep();
      logic [REG_W-1:0] vals [NUM_REGS];
      int f;
      vals = '{pack3(1 << 20 - 1, 1 << 20 - 1, 1 << 20 - 1), pack3(1 << 20 - 1, 0, 1),
               pack3(0, 0, 1 << 20 - 1), pack3(1 << 20 - 1, 1 << 20 - 1, 1 << 20 - 1),
               pack3(1 << 20 - 1, 0, 0), pack3(0, 1 << 20 - 1, 0),
               pack3(0, 0, 1 << 20 - 1)};
      load_config(vals);
      run_points(15);
      wait_drained();
      for (int i = 0; i < NUM_REGS; i++) vals[i] = pack3(-(1 << 20), -(1 << 20), -(1 << 20));
      load_config(vals);
      run_points(15);
      wait_drained();
      for (int i = 0; i < NUM_REGS; i++) vals[i] = '1;
      load_config(vals);
      write_reg(3'd7, '1);
      csr_wr_en <= 0;
      run_points(10);
      wait_drained();
      for (int i = 0; i < NUM_REGS; i++) vals[i] = '0;
      load_config(vals);
      run_points(10);
      wait_drained();
      for (int phase = 0; phase < 7; phase++) begin
         f = $urandom_range(256, (1 << 20) - 1);
         vals[REG_ROT0] = pack3($urandom_range(400000, 524287), rnd_signed(60000),
                                rnd_signed(60000));
         vals[REG_ROT1] = pack3(rnd_signed(60000), $urandom_range(400000, 524287),
                                rnd_signed(60000));
         vals[REG_ROT2] = pack3(rnd_signed(60000), rnd_signed(60000),
                                $urandom_range(400000, 524287));
         vals[REG_TRANS] = pack3(rnd_signed(1 << 14), rnd_signed(1 << 14),
                                 rnd_signed(1 << 14));
         vals[REG_CAM0] = pack3(f, rnd_signed(256), rnd_signed(1 << 18));
         vals[REG_CAM1] = pack3(0, f, rnd_signed(1 << 18));
         vals[REG_CAM2] = pack3(0, 0, 256);
         if (phase == 6) begin
            for (int i = 0; i < NUM_REGS; i++) vals[i] = 63'({$urandom, $urandom});
         end
         load_config(vals);
         run_points(70);
         wait_drained();
      end
      load_config(REG_RESET);
   endtask

   task automatic test_result_backpressure();
      req_type it;
      long_hold_req = 1;
      for (int i = 0; i < 6; i++) begin
         it = plausible_point(i % 2);
         send_point(it);
      end
      run_points(40);
      wait_drained();
   endtask

   task automatic test_random_traffic();
      run_points(250);
      wait_drained();
      idle_on = 0;
      run_points(150);
      wait_drained();
   endtask

   initial begin
      rsp_ch.ready = 0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 0;
            rsp_ch.ready <= 0;
            repeat (2000) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 0;
            repeat ($urandom_range(1, 9) - 1) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      mean_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_means.size() == 0) begin
            $error("unexpected result mean_error %0d", rsp_ch.mean_error);
            error_count++;
         end else begin
            want = pending_means.pop_front();
            if (rsp_ch.mean_error !== want.mean_error) begin
               $error("mean_error expected %0d actual %0d", want.mean_error, rsp_ch.mean_error);
               error_count++;
            end
            if (rsp_ch.item_total !== want.item_total) begin
               $error("item_total expected %0d actual %0d", want.item_total, rsp_ch.item_total);
               error_count++;
            end
            if (rsp_ch.depth_fault !== want.depth_fault) begin
               $error("depth_fault expected %0d actual %0d", want.depth_fault,
                      rsp_ch.depth_fault);
               error_count++;
            end
         end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles > 20000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1;
      csr_wr_en = 0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 0;
      req_ch.model_x = 0; req_ch.model_y = 0; req_ch.model_z = 0;
      req_ch.normal_x = 0; req_ch.normal_y = 0; req_ch.normal_z = 0;
      req_ch.mirror_dist = 0; req_ch.obs_u = 0; req_ch.obs_v = 0; req_ch.last = 0;
      cfg_shadow = REG_RESET;
      err_total = 0;
      pt_count = 0;
      fault_flag = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_config_sweep();
      test_result_backpressure();
      test_random_traffic();
      if (error_count == 0 && pending_means.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ sim.f @@
hdl/mre_pkg.sv
hdl/mre_if.sv
hdl/mre_datapath.sv
hdl/mre_ctrl.sv
hdl/mirror_reprojection_error_unit.sv
tb/tb_mirror_reprojection_error_unit.sv
